// ===== design/tsg_pkg.sv =====
`timescale 1ns / 1ps
package tsg_pkg;

  localparam int unsigned PktLen = 40;

  // Fixed header values
  localparam logic [7:0]  IpVerIhl   = 8'h45;
  localparam logic [15:0] IpTotalLen = 16'd40;
  localparam logic [15:0] IpId       = 16'd12345;
  localparam logic [7:0]  IpTtl      = 8'd64;
  localparam logic [7:0]  ProtoTcp   = 8'd6;
  localparam logic [15:0] TcpHdrLen  = 16'd20;
  localparam logic [7:0]  TcpOffset  = 8'h50;
  localparam logic [7:0]  TcpFlags   = 8'h02;
  localparam logic [15:0] TcpWindow  = 16'd1024;

  // Sums of the fixed 16-bit words that enter each checksum
  localparam logic [17:0] IpConstSum = 18'({IpVerIhl, 8'h00}) + 18'(IpTotalLen) +
                                       18'(IpId) + 18'({IpTtl, ProtoTcp});
  localparam logic [17:0] TcpConstSum = 18'({8'h00, ProtoTcp}) + 18'(TcpHdrLen) +
                                        18'({TcpOffset, TcpFlags}) + 18'(TcpWindow);

  localparam logic [5:0] LastOffset = 6'(PktLen - 1);

  // Configuration register indexes
  localparam logic [2:0] RegSourceAddress   = 3'd0;
  localparam logic [2:0] RegTargetAddress   = 3'd1;
  localparam logic [2:0] RegLocalPort       = 3'd2;
  localparam logic [2:0] RegInitialSequence = 3'd3;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] target_address;
    logic [15:0] local_port;
    logic [31:0] initial_sequence;
  } tsg_cfg_t;

  // One packet waiting to be serialized
  typedef struct packed {
    logic [15:0] probe_port;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
  } tsg_job_t;

endpackage

// ===== design/tsg_front.sv =====
`timescale 1ns / 1ps
module tsg_front
  import tsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  tsg_cfg_t    cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_probe_port,
  output logic        push_valid,
  input  logic        push_full,
  output tsg_job_t    push_job
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [15:0] s1_port_r;
  logic        s2_valid_r, s2_valid_nxt;
  logic [15:0] s2_port_r;
  logic [17:0] s2_addr_sum_r;
  logic [17:0] s2_tcp_sum_r;
  logic        s1_adv, s2_adv;
  logic [19:0] ip_total, tcp_total;

  function automatic logic [15:0] fold_cpl(input logic [19:0] s);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = {1'b0, s[15:0]} + {13'b0, s[19:16]};
    f2 = f1[15:0] + {15'b0, f1[16]};
    return ~f2;
  endfunction

  assign s2_adv   = !s2_valid_r || !push_full;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = !s1_adv;

  assign s1_valid_nxt = s1_adv ? in_valid : s1_valid_r;
  assign s2_valid_nxt = s2_adv ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Address words are shared by both checksums; the rest is TCP only
  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_port_r <= in_probe_port;
    end
    if (s2_adv && s1_valid_r) begin
      s2_port_r     <= s1_port_r;
      s2_addr_sum_r <= 18'(cfg.source_address[31:16]) + 18'(cfg.source_address[15:0]) +
                       18'(cfg.target_address[31:16]) + 18'(cfg.target_address[15:0]);
      s2_tcp_sum_r  <= 18'(cfg.local_port) + 18'(s1_port_r) +
                       18'(cfg.initial_sequence[31:16]) + 18'(cfg.initial_sequence[15:0]);
    end
  end

  assign ip_total  = 20'(s2_addr_sum_r) + 20'(IpConstSum);
  assign tcp_total = 20'(s2_addr_sum_r) + 20'(s2_tcp_sum_r) + 20'(TcpConstSum);

  assign push_valid          = s2_valid_r && !push_full;
  assign push_job.probe_port = s2_port_r;
  assign push_job.ip_csum    = fold_cpl(ip_total);
  assign push_job.tcp_csum   = fold_cpl(tcp_total);

endmodule

// ===== design/tsg_queue.sv =====
`timescale 1ns / 1ps
module tsg_queue
  import tsg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_full,
  input  tsg_job_t push_job,
  output logic     pop_valid,
  input  logic     pop_ready,
  output tsg_job_t pop_job
);

  tsg_job_t    entry_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r, count_nxt;
  logic        do_push, do_pop;

  assign push_full = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_job   = entry_r[rd_ptr_r];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== design/tsg_back.sv =====
`timescale 1ns / 1ps
module tsg_back
  import tsg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tsg_cfg_t   cfg,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  tsg_job_t   pop_job,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_packet_byte,
  output logic [5:0] out_byte_offset,
  output logic       out_end_of_packet
);

  logic       busy_r, busy_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  tsg_job_t   job_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [5:0] out_offset_r;
  logic       out_eop_r;
  logic       out_adv, emit, last;
  logic [7:0] cur_byte;

  assign out_adv   = !out_valid_r || !out_stall;
  assign emit      = busy_r && out_adv;
  assign last      = (cnt_r == LastOffset);
  assign pop_ready = !busy_r || (emit && last);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (emit) begin
      cnt_nxt = cnt_r + 6'd1;
      if (last) busy_nxt = 1'b0;
    end
    if (pop_ready && pop_valid) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
    end
  end

  always_comb begin
    case (cnt_r)
      6'd0:    cur_byte = IpVerIhl;
      6'd2:    cur_byte = IpTotalLen[15:8];
      6'd3:    cur_byte = IpTotalLen[7:0];
      6'd4:    cur_byte = IpId[15:8];
      6'd5:    cur_byte = IpId[7:0];
      6'd8:    cur_byte = IpTtl;
      6'd9:    cur_byte = ProtoTcp;
      6'd10:   cur_byte = job_r.ip_csum[15:8];
      6'd11:   cur_byte = job_r.ip_csum[7:0];
      6'd12:   cur_byte = cfg.source_address[31:24];
      6'd13:   cur_byte = cfg.source_address[23:16];
      6'd14:   cur_byte = cfg.source_address[15:8];
      6'd15:   cur_byte = cfg.source_address[7:0];
      6'd16:   cur_byte = cfg.target_address[31:24];
      6'd17:   cur_byte = cfg.target_address[23:16];
      6'd18:   cur_byte = cfg.target_address[15:8];
      6'd19:   cur_byte = cfg.target_address[7:0];
      6'd20:   cur_byte = cfg.local_port[15:8];
      6'd21:   cur_byte = cfg.local_port[7:0];
      6'd22:   cur_byte = job_r.probe_port[15:8];
      6'd23:   cur_byte = job_r.probe_port[7:0];
      6'd24:   cur_byte = cfg.initial_sequence[31:24];
      6'd25:   cur_byte = cfg.initial_sequence[23:16];
      6'd26:   cur_byte = cfg.initial_sequence[15:8];
      6'd27:   cur_byte = cfg.initial_sequence[7:0];
      6'd32:   cur_byte = TcpOffset;
      6'd33:   cur_byte = TcpFlags;
      6'd34:   cur_byte = TcpWindow[15:8];
      6'd35:   cur_byte = TcpWindow[7:0];
      6'd36:   cur_byte = job_r.tcp_csum[15:8];
      6'd37:   cur_byte = job_r.tcp_csum[7:0];
      default: cur_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      if (out_adv) out_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      job_r <= pop_job;
    end
    if (emit) begin
      out_byte_r   <= cur_byte;
      out_offset_r <= cnt_r;
      out_eop_r    <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packet_byte   = out_byte_r;
  assign out_byte_offset   = out_offset_r;
  assign out_end_of_packet = out_eop_r;

endmodule

// ===== design/tcp_syn_packet_generator.sv =====
`timescale 1ns / 1ps
// Builds one 40-byte IPv4+TCP SYN packet per accepted probe port and streams it out
// one byte per cycle while out_stall is low, in wire order, flagging the last byte.
// The byte serializer counts out the bytes of each packet; with the output not
// stalled, back-to-back ports give a continuous byte stream. The front end computes
// both checksums in two register stages and parks up to two finished jobs in a small
// queue, so new ports are taken while the current packet is still going out. A port
// reaches the output through the two front-end stages, the queue, and the serializer's
// job and output registers. Change the address, port and sequence registers only
// while no packet is in flight.
module tcp_syn_packet_generator
  import tsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_probe_port,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_packet_byte,
  output logic [5:0]  out_byte_offset,
  output logic        out_end_of_packet
);

  tsg_cfg_t cfg_r;
  logic     push_valid, push_full;
  tsg_job_t push_job;
  logic     pop_valid, pop_ready;
  tsg_job_t pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSourceAddress:   cfg_r.source_address   <= cfg_data;
        RegTargetAddress:   cfg_r.target_address   <= cfg_data;
        RegLocalPort:       cfg_r.local_port       <= cfg_data[15:0];
        RegInitialSequence: cfg_r.initial_sequence <= cfg_data;
        default: ;
      endcase
    end
  end

  tsg_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_probe_port (in_probe_port),
    .push_valid    (push_valid),
    .push_full     (push_full),
    .push_job      (push_job)
  );

  tsg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  tsg_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_job           (pop_job),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packet_byte   (out_packet_byte),
    .out_byte_offset   (out_byte_offset),
    .out_end_of_packet (out_end_of_packet)
  );

endmodule
